// ===== design/rpf_pkg.sv =====
// package with item types, register indexes and double compare helpers
`timescale 1ns / 1ps
`default_nettype none
package rpf_pkg;

    localparam int unsigned DefMaxRows = 16777216;
    localparam int unsigned CntW = 25;
    localparam int unsigned IdxW = 24;
    localparam int unsigned RegIdxW = 3;
    localparam int unsigned CfgDataW = 64;

    localparam logic [RegIdxW-1:0] REG_MODE = 3'd0;
    localparam logic [RegIdxW-1:0] REG_THR = 3'd1;
    localparam logic [RegIdxW-1:0] REG_KEY = 3'd2;
    localparam logic [RegIdxW-1:0] REG_SLO = 3'd3;
    localparam logic [RegIdxW-1:0] REG_SHI = 3'd4;
    localparam logic [RegIdxW-1:0] REG_DMIN = 3'd5;
    localparam logic [RegIdxW-1:0] REG_DMAX = 3'd6;
    localparam logic [RegIdxW-1:0] REG_QLIM = 3'd7;

    localparam logic [2:0] Q_COUNT = 3'd0;
    localparam logic [2:0] Q_GREATER = 3'd1;
    localparam logic [2:0] Q_EQUAL = 3'd2;
    localparam logic [2:0] Q_KEY = 3'd3;
    localparam logic [2:0] Q_WINDOW = 3'd4;

    typedef struct packed {
        logic signed [31:0] ord_key;
        logic signed [31:0] line_no;
        logic [63:0] quantity;
        logic [63:0] ext_price;
        logic [63:0] discount;
        logic signed [31:0] ship_date;
        logic final_row;
    } t_in_item;

    typedef struct packed {
        logic kind;
        logic [IdxW-1:0] row_index;
        logic signed [31:0] key_order;
        logic signed [31:0] key_line;
        logic whole_row;
        logic [CntW-1:0] match_count;
        logic [CntW-1:0] rows_seen;
        logic done_res;
    } t_out_item;

    typedef struct packed {
        logic [3:0] query_mode;
        logic [63:0] price_threshold;
        logic [63:0] point_key;
        logic signed [31:0] ship_low;
        logic signed [31:0] ship_high;
        logic [63:0] discount_min;
        logic [63:0] discount_max;
        logic [63:0] quantity_limit;
    } t_cfg;

    function automatic logic is_nan(input logic [63:0] a);
        return (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
    endfunction

    // a < b in ieee ordering
    function automatic logic dbl_lt(input logic [63:0] a, input logic [63:0] b);
        logic az;
        logic bz;
        logic r;
        az = (a[62:0] == 63'd0);
        bz = (b[62:0] == 63'd0);
        if (is_nan(a) || is_nan(b) || (az && bz)) begin
            r = 1'b0;
        end else if (a[63] != b[63]) begin
            r = a[63];
        end else if (a[63]) begin
            r = a[62:0] > b[62:0];
        end else begin
            r = a[62:0] < b[62:0];
        end
        return r;
    endfunction

    function automatic logic dbl_eq(input logic [63:0] a, input logic [63:0] b);
        return !is_nan(a) && !is_nan(b) &&
            ((a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)));
    endfunction

endpackage
`default_nettype wire

// ===== design/row_predicate_filter.sv =====
// top level of the row predicate filter
`timescale 1ns / 1ps
`default_nettype none
// Takes one row item per cycle unless o_stall is high. A row item is registered,
// evaluated against the configured query by parallel compares and the counters in
// the next cycle, and its results (a matching-row item, and on the final row a
// summary item) go into a four-entry output queue. The input stalls while the queue
// plus the results of the registered row leave fewer than two free entries. With a
// free-running consumer and at most one result per row the rate is one row per
// cycle; a matching final row makes two results, and the second waits its turn
// at the output.
module row_predicate_filter #(
    parameter longint unsigned MAX_ROWS = rpf_pkg::DefMaxRows
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire rpf_pkg::t_in_item            i_item,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output rpf_pkg::t_out_item                o_item,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [rpf_pkg::RegIdxW-1:0]  i_cfg_index,
    input  wire logic [rpf_pkg::CfgDataW-1:0] i_cfg_data
);
    import rpf_pkg::*;

    localparam longint unsigned CntFull = (64'd1 << CntW) - 64'd1;
    localparam longint unsigned IdxFull = (64'd1 << IdxW) - 64'd1;
    localparam logic [CntW-1:0] CntCap =
        CntW'((MAX_ROWS > CntFull) ? CntFull : MAX_ROWS);
    localparam logic [IdxW-1:0] IdxCap =
        IdxW'((MAX_ROWS - 64'd1 > IdxFull) ? IdxFull : MAX_ROWS - 64'd1);
    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW = 2;

    t_cfg cfg;
    rpf_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    // input register
    logic r_in_v;
    t_in_item r_in;
    logic [CntW-1:0] r_rows, r_hits;

    // output queue
    t_out_item r_q [QDepth];
    logic [QPtrW-1:0] r_rd, r_wr;
    logic [QPtrW-1:0] wr_next;
    logic [2:0] r_cnt;
    logic [2:0] load;
    logic pop, accept, fire;
    logic [2:0] query;
    logic hit, emit, push_row;
    logic [1:0] npush, push_n;
    logic [CntW-1:0] n_rows, n_hits;
    t_out_item row_res, sum_res;

    // room for the registered row's results and two more
    assign load = r_cnt + {1'b0, push_n};
    assign o_stall = load > 3'd2;
    assign accept = i_valid && !o_stall;
    assign o_valid = r_cnt != 3'd0;
    assign o_item = r_q[r_rd];
    assign pop = o_valid && !i_stall;
    // the registered row is evaluated in the cycle after its accept
    assign fire = r_in_v;
    assign push_n = fire ? npush : 2'd0;
    assign wr_next = r_wr + 2'd1;

    assign query = cfg.query_mode[3:1];

    always_comb begin
        hit = 1'b0;
        emit = 1'b0;
        case (query)
            Q_COUNT: hit = dbl_lt(cfg.price_threshold, r_in.ext_price);
            Q_GREATER: begin
                hit = dbl_lt(cfg.price_threshold, r_in.ext_price);
                emit = 1'b1;
            end
            Q_EQUAL: begin
                hit = dbl_eq(r_in.ext_price, cfg.price_threshold);
                emit = 1'b1;
            end
            Q_KEY: begin
                hit = (r_in.ord_key == cfg.point_key[63:32]) &&
                      (r_in.line_no == cfg.point_key[31:0]);
                emit = 1'b1;
            end
            Q_WINDOW: begin
                hit = (r_in.ship_date >= cfg.ship_low) &&
                      (r_in.ship_date < cfg.ship_high) &&
                      dbl_lt(cfg.discount_min, r_in.discount) &&
                      dbl_lt(r_in.discount, cfg.discount_max) &&
                      dbl_lt(r_in.quantity, cfg.quantity_limit);
                emit = 1'b1;
            end
            default: begin
                hit = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_rows = (r_rows < CntCap) ? r_rows + 1'b1 : r_rows;
        n_hits = (hit && r_hits < CntCap) ? r_hits + 1'b1 : r_hits;
        push_row = hit && emit;
        row_res = '0;
        row_res.row_index = (r_rows > CntW'(IdxCap)) ? IdxCap : r_rows[IdxW-1:0];
        row_res.key_order = r_in.ord_key;
        row_res.key_line = r_in.line_no;
        row_res.whole_row = !cfg.query_mode[0];
        sum_res = '0;
        sum_res.kind = 1'b1;
        sum_res.match_count = n_hits;
        sum_res.rows_seen = n_rows;
        sum_res.done_res = 1'b1;
        npush = {1'b0, push_row} + {1'b0, r_in.final_row};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_rows <= '0;
            r_hits <= '0;
            r_cnt <= '0;
            r_rd <= '0;
            r_wr <= '0;
        end else begin
            r_in_v <= accept;
            if (fire) begin
                r_rows <= r_in.final_row ? '0 : n_rows;
                r_hits <= r_in.final_row ? '0 : n_hits;
            end
            r_cnt <= r_cnt - {2'b0, pop} + {1'b0, push_n};
            r_rd <= r_rd + {1'b0, pop};
            r_wr <= r_wr + push_n;
        end
    end

    // queue payload; a row result goes before the summary of the same row
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
        for (int i = 0; i < QDepth; i++) begin
            if (push_n != 2'd0 && QPtrW'(i) == r_wr) begin
                r_q[i] <= push_row ? row_res : sum_res;
            end else if (push_n == 2'd2 && QPtrW'(i) == wr_next) begin
                r_q[i] <= sum_res;
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/rpf_regs.sv =====
// configuration register file
`timescale 1ns / 1ps
`default_nettype none
module rpf_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [rpf_pkg::RegIdxW-1:0] i_cfg_index,
    input  wire logic [rpf_pkg::CfgDataW-1:0] i_cfg_data,
    output rpf_pkg::t_cfg                    o_cfg
);
    import rpf_pkg::*;

    t_cfg r_cfg;
    logic wr;

    assign o_cfg_ready = 1'b1;
    assign wr = i_cfg_valid;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            case (i_cfg_index)
                REG_MODE: r_cfg.query_mode <= i_cfg_data[3:0];
                REG_THR: r_cfg.price_threshold <= i_cfg_data;
                REG_KEY: r_cfg.point_key <= i_cfg_data;
                REG_SLO: r_cfg.ship_low <= i_cfg_data[31:0];
                REG_SHI: r_cfg.ship_high <= i_cfg_data[31:0];
                REG_DMIN: r_cfg.discount_min <= i_cfg_data;
                REG_DMAX: r_cfg.discount_max <= i_cfg_data;
                REG_QLIM: r_cfg.quantity_limit <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end
endmodule
`default_nettype wire
